// ===== design/lzwp_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwp_pkg
// Shared constants and types of the LZW variable-width code packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwp_pkg;

   localparam int MAX_WIDTH = 16;

   // Code width limit: MAX_WIDTH held to the range 9..16.
   localparam int WIDTH_LIMIT_INT = (MAX_WIDTH > 16) ? 16 : ((MAX_WIDTH < 9) ? 9 : MAX_WIDTH);
   localparam logic [4:0] WIDTH_LIMIT = 5'(WIDTH_LIMIT_INT);
   localparam logic [4:0] MIN_WIDTH = 5'd9;
   localparam logic [4:0] START_WIDTH_RESET = 5'd9;

   localparam int CODE_BITS = 16;
   localparam int BYTE_BITS = 8;
   localparam int MAX_BYTES = 3;

   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_INDEX_START_WIDTH = 1'b0;

   // Everything one code produces: up to three bytes and the next packer state.
   typedef struct packed {
      logic [MAX_BYTES*BYTE_BITS-1:0] bytes;
      logic [1:0] byte_count;
      logic eos;
      logic [6:0] pending_bits;
      logic [2:0] pending_count;
      logic [4:0] width;
   } pack_result_type;

endpackage : lzwp_pkg

`default_nettype wire

// ===== design/lzw_variable_width_code_packer_core.sv =====
// ----------------------------------------------------------------------------
// lzw_variable_width_code_packer_core
// Packs LZW codes of a growing width into bytes, least significant bit first.
// ----------------------------------------------------------------------------
// Each accepted item packs one code, masked to the current width, above the
// bits left over from earlier codes and yields one to three bytes on the
// result channel, one byte per cycle while the result channel does not stall;
// the last byte of an item carries last_of_item, and the last byte of a
// stream carries stream_last. The bytes of an item pass one at a time through
// the single byte-wide result register: at width 9 most codes fill one byte,
// wider codes fill one or two bytes depending on the pending bit count,
// 16-bit codes always fill two, and an end of stream that adds a partial
// byte to two full ones yields three. The
// packer state (pending bits, their count, the code width) is updated the
// moment an item is accepted, so the next item is taken in the cycle its
// predecessor's final byte moves into the result register. When probe_enable
// is set and probe_value is all ones at the current width, the width grows
// by one after the code, up to the width limit. An end of stream flushes a
// partial byte zero-padded and returns the width to start_width, the only
// configuration register (byte address 0, values below 9 act as 9 and values
// above the limit as the limit). A start_width write takes effect at the next
// stream end.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_variable_width_code_packer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input items
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [lzwp_pkg::CODE_BITS-1:0]     req_code,
   input  wire logic [lzwp_pkg::CODE_BITS-1:0]     req_probe_value,
   input  wire logic                               req_probe_enable,
   input  wire logic                               req_end_of_stream,
   // Result items
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [lzwp_pkg::BYTE_BITS-1:0]          rsp_out_byte,
   output logic                                    rsp_last_of_item,
   output logic                                    rsp_stream_last,
   // Configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lzwp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   import lzwp_pkg::*;

   // Configuration register and its clamped value.
   logic [4:0] start_width_ff, start_width_in;
   logic [4:0] start_eff;

   // Packer state.
   logic [6:0] pending_bits_ff, pending_bits_in;
   logic [2:0] pending_count_ff, pending_count_in;
   logic [4:0] width_ff, width_in;

   // Bytes of the current item still waiting for the result register.
   logic [MAX_BYTES*BYTE_BITS-1:0] burst_bytes_ff, burst_bytes_in;
   logic [1:0]                     burst_count_ff, burst_count_in;
   logic                           burst_eos_ff, burst_eos_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0] rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_stream_ff, rsp_stream_in;

   pack_result_type pack;
   logic csr_write;
   logic out_load;
   logic accept;

   always_comb begin
      if (start_width_ff < MIN_WIDTH) begin
         start_eff = MIN_WIDTH;
      end else if (start_width_ff > WIDTH_LIMIT) begin
         start_eff = WIDTH_LIMIT;
      end else begin
         start_eff = start_width_ff;
      end
   end

   lzwp_pack u_pack (
      .code          (req_code),
      .probe_value   (req_probe_value),
      .probe_enable  (req_probe_enable),
      .end_of_stream (req_end_of_stream),
      .pending_bits  (pending_bits_ff),
      .pending_count (pending_count_ff),
      .current_width (width_ff),
      .start_width   (start_eff),
      .result        (pack)
   );

   // The result register takes a byte whenever it is empty or being emptied.
   assign out_load  = (burst_count_ff != 2'd0) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((burst_count_ff == 2'd0) || ((burst_count_ff == 2'd1) && out_load));
   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      start_width_in = start_width_ff;
      if (csr_write && (csr_paddr[2] == CSR_INDEX_START_WIDTH)) begin
         start_width_in = csr_pwdata[4:0];
      end

      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      width_in         = width_ff;
      burst_bytes_in   = burst_bytes_ff;
      burst_count_in   = burst_count_ff;
      burst_eos_in     = burst_eos_ff;
      if (accept) begin
         pending_bits_in  = pack.pending_bits;
         pending_count_in = pack.pending_count;
         width_in         = pack.width;
         burst_bytes_in   = pack.bytes;
         burst_count_in   = pack.byte_count;
         burst_eos_in     = pack.eos;
      end else if (out_load) begin
         burst_bytes_in = {8'b0, burst_bytes_ff[MAX_BYTES*BYTE_BITS-1:BYTE_BITS]};
         burst_count_in = burst_count_ff - 2'd1;
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_stream_in = rsp_stream_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = burst_bytes_ff[BYTE_BITS-1:0];
         rsp_last_in   = (burst_count_ff == 2'd1);
         rsp_stream_in = (burst_count_ff == 2'd1) && burst_eos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_width_ff   <= START_WIDTH_RESET;
         pending_bits_ff  <= 7'd0;
         pending_count_ff <= 3'd0;
         width_ff         <= START_WIDTH_RESET;
         burst_count_ff   <= 2'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_width_ff   <= start_width_in;
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         width_ff         <= width_in;
         burst_count_ff   <= burst_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_bytes_ff <= burst_bytes_in;
      burst_eos_ff   <= burst_eos_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_stream_ff  <= rsp_stream_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last_of_item = rsp_last_ff;
   assign rsp_stream_last  = rsp_stream_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_INDEX_START_WIDTH) ? {27'b0, start_width_ff} : 32'b0;

endmodule : lzw_variable_width_code_packer_core

`default_nettype wire

// ===== design/lzwp_pack.sv =====
// ----------------------------------------------------------------------------
// lzwp_pack
// Combinational packing of one code above the pending bits, with the width
// growth check and the end-of-stream flush.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwp_pack (
   input  wire logic [lzwp_pkg::CODE_BITS-1:0] code,
   input  wire logic [lzwp_pkg::CODE_BITS-1:0] probe_value,
   input  wire logic                           probe_enable,
   input  wire logic                           end_of_stream,
   input  wire logic [6:0]                     pending_bits,
   input  wire logic [2:0]                     pending_count,
   input  wire logic [4:0]                     current_width,
   input  wire logic [4:0]                     start_width,
   output lzwp_pkg::pack_result_type           result
);
   import lzwp_pkg::*;

   logic [CODE_BITS-1:0] mask;
   logic [CODE_BITS-1:0] code_masked;
   logic [23:0]          acc;
   logic [4:0]           total;
   logic [1:0]           full_bytes;
   logic [6:0]           rest_bits;
   logic                 flush;

   always_comb begin
      mask        = 16'hFFFF >> (5'd16 - current_width);
      code_masked = code & mask;
      acc         = ({8'b0, code_masked} << pending_count) | {17'b0, pending_bits};
      total       = {2'b0, pending_count} + current_width;
      // Each code has at least nine bits, so one or two bytes always fill.
      full_bytes  = total[4:3];
      case (full_bytes)
         2'd1: begin
            rest_bits = acc[14:8];
         end
         default: begin
            rest_bits = acc[22:16];
         end
      endcase
      flush = end_of_stream && (total[2:0] != 3'd0);

      // Bits above the packed total are zero, so the byte after the last full
      // one is already the zero-padded flush byte.
      result.bytes      = acc;
      result.byte_count = full_bytes + {1'b0, flush};
      result.eos        = end_of_stream;

      if (end_of_stream) begin
         result.pending_bits  = 7'd0;
         result.pending_count = 3'd0;
         result.width         = start_width;
      end else begin
         result.pending_bits  = rest_bits;
         result.pending_count = total[2:0];
         if (probe_enable && (probe_value == mask) && (current_width < WIDTH_LIMIT)) begin
            result.width = current_width + 5'd1;
         end else begin
            result.width = current_width;
         end
      end
   end

endmodule : lzwp_pack

`default_nettype wire

// ===== dv/lzw_variable_width_code_packer_core_tb.sv =====
// ----------------------------------------------------------------------------
// lzw_variable_width_code_packer_core_tb
// Self-checking bench for the LZW variable-width code packer.
// ----------------------------------------------------------------------------
// A queue of code items feeds a clocked driver. Each item the block accepts
// runs through a bit-accurate packer model that keeps its own pending bits,
// bit count, code width and start_width copy. The model's bytes go into a
// queue, and a clocked monitor checks each byte the block hands out against
// the oldest one there. The run starts with hand-picked codes (width growth
// up to saturation, disabled and near-miss probes, flushes with and without
// a partial byte), then random streams, one phase per start_width setting,
// with random gaps and stalls (none in the third) and one long output stall.
// ----------------------------------------------------------------------------

module lzw_variable_width_code_packer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lzwp_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] START_WIDTH_ADDR = 3'd0;
   // Byte address of a register that does not exist: writes there must be ignored.
   localparam logic [CSR_ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;
   localparam int PHASE_ITEMS = 37;
   localparam logic [4:0] START_PLAN [8] = '{5'd16, 5'd0, 5'd31, 5'd12, 5'd8, 5'd17,
                                             5'd10, 5'd9};

   typedef struct {
      logic [CODE_BITS-1:0] code;
      logic [CODE_BITS-1:0] probe_value;
      logic                 probe_enable;
      logic                 end_of_stream;
   } code_item_t;

   typedef struct {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_of_item;
      logic                 stream_last;
   } packed_byte_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CODE_BITS-1:0] req_code = '0;
   logic [CODE_BITS-1:0] req_probe_value = '0;
   logic                 req_probe_enable = 1'b0;
   logic                 req_end_of_stream = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   logic [BYTE_BITS-1:0] rsp_out_byte;
   logic                 rsp_last_of_item;
   logic                 rsp_stream_last;

   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // Packer model state, advanced once for each accepted item.
   logic [6:0] held_bits = '0;
   logic [2:0] held_count = '0;
   logic [4:0] code_width = START_WIDTH_RESET;
   logic [4:0] start_width_reg = START_WIDTH_RESET;

   code_item_t   pending_items[$];
   packed_byte_t expected_bytes[$];

   // The random generator keeps its own view of the width, so that it can
   // aim probes at the all-ones value that makes the width grow.
   logic [4:0] plan_width = START_WIDTH_RESET;
   int         stream_left = 5;

   bit quiet = 1'b1;
   int errors = 0;
   int bytes_seen = 0;

   lzw_variable_width_code_packer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code          (req_code),
      .req_probe_value   (req_probe_value),
      .req_probe_enable  (req_probe_enable),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_stream_last   (rsp_stream_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The width a stream end returns to: start_width held to 9..limit.
   function automatic logic [4:0] clamp_start();
      if (start_width_reg < MIN_WIDTH) return MIN_WIDTH;
      if (start_width_reg > WIDTH_LIMIT) return WIDTH_LIMIT;
      return start_width_reg;
   endfunction

   // Packs one code and queues the bytes it yields, with their flags.
   function automatic void pack_code(code_item_t it);
      packed_byte_t made[3];
      logic [4:0]   w;
      logic [31:0]  ones;
      logic [31:0]  acc;
      int unsigned  bits;
      int           n;
      w = code_width;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
      ones = (32'd1 << w) - 32'd1;
      // New code bits sit above the bits still held from earlier codes.
      acc = {25'd0, held_bits} | (({16'd0, it.code} & ones) << held_count);
      bits = held_count + w;
      n = 0;
      while (bits >= 8 && n < 3) begin
         made[n] = '{out_byte: acc[7:0], last_of_item: 1'b0, stream_last: 1'b0};
         acc = acc >> 8;
         bits = bits - 8;
         n++;
      end
      held_bits = acc[6:0];
      held_count = 3'(bits);
      // The growth check uses the width the code was packed at.
      if (it.probe_enable && {16'd0, it.probe_value} == ones && w < WIDTH_LIMIT) w++;
      code_width = w;
      if (it.end_of_stream) begin
         // A partial byte goes out zero-padded; on a byte boundary nothing is added.
         if (held_count != 0 && n < 3) begin
            made[n] = '{out_byte: {1'b0, held_bits}, last_of_item: 1'b0, stream_last: 1'b0};
            n++;
         end
         if (n > 0) made[n-1].stream_last = 1'b1;
         held_bits = '0;
         held_count = '0;
         code_width = clamp_start();
      end
      if (n > 0) made[n-1].last_of_item = 1'b1;
      for (int k = 0; k < n; k++) expected_bytes.push_back(made[k]);
   endfunction

   // Mostly no idling, some short gaps and now and then a long one.
   function automatic int idle_length();
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Random items are mostly well-formed streams: probes aimed at the width
   // that the stream has reached, near misses, and an end of stream after a
   // random number of codes. About one in ten is plain noise.
   function automatic code_item_t random_item();
      code_item_t     it;
      logic [15:0]    ones;
      int             pick;
      ones = 16'((32'd1 << plan_width) - 32'd1);
      it.code = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         it.probe_value = 16'($urandom_range(0, 65535));
         it.probe_enable = 1'($urandom_range(0, 1));
         it.end_of_stream = ($urandom_range(0, 7) == 0);
      end else begin
         if (pick < 40) begin
            it.probe_value = ones;
            it.probe_enable = 1'b1;
         end else if (pick < 55) begin
            it.probe_value = ones ^ (16'd1 << $urandom_range(0, 15));
            it.probe_enable = 1'b1;
         end else begin
            it.probe_value = 16'($urandom_range(0, 65535));
            it.probe_enable = 1'($urandom_range(0, 1));
         end
         it.end_of_stream = (stream_left == 0);
         if (stream_left == 0)
            stream_left = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(3, 30);
         else
            stream_left--;
      end
      if (it.probe_enable && it.probe_value == ones && plan_width < WIDTH_LIMIT)
         plan_width++;
      if (it.end_of_stream) plan_width = clamp_start();
      return it;
   endfunction

   function automatic void queue_item(logic [15:0] code, logic [15:0] probe,
                                      logic probe_on, logic eos);
      pending_items.push_back('{code: code, probe_value: probe, probe_enable: probe_on,
                                end_of_stream: eos});
   endfunction

   // One APB transfer: a setup phase, then the access phase until pready.
   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Writes start_width with junk in the upper bits, then writes the unused
   // address, which must change nothing, and reads the register back.
   task automatic program_start_width(input logic [4:0] value);
      logic [31:0] readback;
      csr_access(1'b1, START_WIDTH_ADDR, {27'($urandom), value}, readback);
      start_width_reg = value;
      csr_access(1'b1, UNUSED_ADDR, {27'($urandom), ~value}, readback);
      csr_access(1'b0, START_WIDTH_ADDR, 32'd0, readback);
      if (readback !== {27'd0, value}) begin
         $display("%0t: start_width readback expected %0d actual %0d", $time, value, readback);
         errors++;
      end
      @(negedge clock);
   endtask

   // Idle means every item taken and every byte out; checked between edges.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0);
   endtask

   // Driver: offers the next item after a random gap. The payload holds
   // while the block stalls, and each accepted item goes through the model.
   code_item_t offered;
   int         gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) pack_code(offered);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               offered = pending_items.pop_front();
               req_code <= offered.code;
               req_probe_value <= offered.probe_value;
               req_probe_enable <= offered.probe_enable;
               req_end_of_stream <= offered.end_of_stream;
               req_valid <= 1'b1;
               gap_left = idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each byte taken against the oldest expectation and
   // drives the output stall. Once, well into the random part and while the
   // driver is offering, it holds the output for a long stretch so that the
   // block fills up and pushes back on its input.
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   packed_byte_t want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte, expected none actual %02h", $time, rsp_out_byte);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte,
                           rsp_out_byte);
                  errors++;
               end
               if (rsp_last_of_item !== want.last_of_item) begin
                  $display("%0t: last_of_item expected %0b actual %0b", $time,
                           want.last_of_item, rsp_last_of_item);
                  errors++;
               end
               if (rsp_stream_last !== want.stream_last) begin
                  $display("%0t: stream_last expected %0b actual %0b", $time,
                           want.stream_last, rsp_stream_last);
                  errors++;
               end
            end
         end
         if (!hold_done && bytes_seen >= 150 && req_valid) begin
            hold_left = 80;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_length();
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset width 9: grow step by step to the limit, try to grow past it,
      // use a disabled probe and near misses, then end one stream on a byte
      // boundary and one with a partial byte left over.
      queue_item(16'h0000, 16'h0000, 1'b0, 1'b0);
      queue_item(16'hFFFF, 16'h01FF, 1'b1, 1'b0);
      queue_item(16'hAAAA, 16'h03FF, 1'b1, 1'b0);
      queue_item(16'h5555, 16'hFFFF, 1'b0, 1'b0);
      queue_item(16'hFFFF, 16'h07FF, 1'b1, 1'b0);
      queue_item(16'h1234, 16'h0FFF, 1'b1, 1'b0);
      queue_item(16'hFFFF, 16'h1FFF, 1'b1, 1'b0);
      queue_item(16'h8001, 16'h3FFF, 1'b1, 1'b0);
      queue_item(16'hFFFF, 16'h7FFF, 1'b1, 1'b0);
      queue_item(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      queue_item(16'h0000, 16'hFFFE, 1'b1, 1'b0);
      queue_item(16'hFFFF, 16'h0000, 1'b0, 1'b1);
      queue_item(16'h01FF, 16'h01FE, 1'b1, 1'b1);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         program_start_width(p == 6 ? 5'($urandom_range(0, 31)) : START_PLAN[p]);
         if (p == 0) begin
            // The new start width only applies after the next stream end, so
            // the first code still packs at 9 bits. The 16-bit codes after it
            // land on byte boundaries, and the stream ends without padding.
            queue_item(16'h0000, 16'h0000, 1'b0, 1'b1);
            queue_item(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
            queue_item(16'h0000, 16'h0000, 1'b0, 1'b0);
            queue_item(16'hA5C3, 16'h0000, 1'b0, 1'b1);
            queue_item(16'h7E81, 16'hFFFF, 1'b1, 1'b1);
            wait_idle();
         end
         quiet = (p == 2);
         plan_width = code_width;
         repeat (PHASE_ITEMS) pending_items.push_back(random_item());
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (errors == 0 && expected_bytes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Ends a hung run; a correct run needs well under a fifth of this.
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/lzwp_pkg.sv
design/lzwp_pack.sv
design/lzw_variable_width_code_packer_core.sv
dv/lzw_variable_width_code_packer_core_tb.sv
